// ===== hdl/mras_pkg.sv =====
// Package for the mixed-radix address step block: sizes, codes, transaction types
// and the digit helper functions.
// Depends on nothing; every other file of the block uses it by scoped names.
package mras_pkg;

  localparam int MAX_DEPTH     = 4;
  localparam int ALPHABET_SIZE = 256;
  localparam int COUPLET_SPACE = 65536;

  localparam int ADDR_W   = 64;
  localparam int ELEM_W   = 16;
  localparam int SYM_W    = 8;
  localparam int FDEPTH_W = 3;
  localparam int PART_W   = 4;
  localparam int STATUS_W = 3;
  localparam int RUN_W    = 64;
  localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
  localparam int DIGIT_W  = $clog2(COUPLET_SPACE);
  localparam int DIFF_W   = DIGIT_W + 2;
  localparam int VAL_W    = ELEM_W + 1;
  localparam int RCP_W    = 34;
  localparam int PROD_W   = VAL_W + RCP_W;
  localparam int RCP_SH   = 32;

  localparam logic [RCP_W-1:0] RECIP_C = RCP_W'((64'd1 << RCP_SH) / COUPLET_SPACE + 1);
  localparam logic [RCP_W-1:0] RECIP_A = RCP_W'((64'd1 << RCP_SH) / ALPHABET_SIZE + 1);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(COUPLET_SPACE - 1);

  typedef enum logic {
    OP_SUCC = 1'b0,
    OP_SPAN = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_PARTIAL   = 3'd2,
    ST_CARRY     = 3'd3,
    ST_DEPTH     = 3'd4,
    ST_BACKWARD  = 3'd5,
    ST_TOO_LARGE = 3'd6
  } status_t;

  typedef logic [CNT_W-1:0] depth_t;
  typedef logic [MAX_DEPTH-1:0][DIGIT_W-1:0] digit_vec_t;
  typedef logic [MAX_DEPTH-1:0][ELEM_W-1:0] elem_vec_t;

  typedef struct packed {
    logic                opcode;
    logic [ADDR_W-1:0]   origin_digits;
    logic [FDEPTH_W-1:0] origin_depth;
    logic [PART_W-1:0]   origin_partial;
    logic [ADDR_W-1:0]   bound_digits;
    logic [FDEPTH_W-1:0] bound_depth;
    logic [PART_W-1:0]   bound_partial;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   next_digits;
    logic [RUN_W-1:0]    run_length;
  } rsp_t;

  typedef struct packed {
    op_t        op;
    depth_t     on;
    depth_t     bn;
    logic       o_part;
    logic       b_part;
    digit_vec_t od;
    digit_vec_t bd;
    elem_vec_t  oraw;
  } dec_t;

  typedef struct packed {
    op_t                  op;
    status_t              status;
    depth_t               depth;
    logic [MAX_DEPTH-1:0] inc;
    logic [MAX_DEPTH-1:0] zero;
    digit_vec_t           val;
    elem_vec_t            oraw;
  } arith_t;

  typedef struct packed {
    op_t               op;
    status_t           status;
    logic [ADDR_W-1:0] next;
    logic [RUN_W-1:0]  sum_a;
    logic [RUN_W-1:0]  sum_b;
  } conv_t;

  function automatic logic [DIGIT_W-1:0] digit_of(logic [ELEM_W-1:0] e);
    logic [VAL_W-1:0]  v;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] qc;
    v    = VAL_W'(VAL_W'(e[ELEM_W-1:SYM_W]) * VAL_W'(ALPHABET_SIZE)) + VAL_W'(e[SYM_W-1:0]);
    prod = PROD_W'(v) * PROD_W'(RECIP_C);
    qc   = PROD_W'(prod[PROD_W-1:RCP_SH]) * PROD_W'(COUPLET_SPACE);
    return DIGIT_W'(v - qc[VAL_W-1:0]);
  endfunction

  function automatic logic [ELEM_W-1:0] split_code(logic [DIGIT_W-1:0] code);
    logic [VAL_W-1:0]  c;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] qa;
    logic [VAL_W-1:0]  s;
    c    = VAL_W'(code);
    prod = PROD_W'(c) * PROD_W'(RECIP_A);
    qa   = PROD_W'(prod[PROD_W-1:RCP_SH]) * PROD_W'(ALPHABET_SIZE);
    s    = c - qa[VAL_W-1:0];
    return {prod[RCP_SH+SYM_W-1:RCP_SH], s[SYM_W-1:0]};
  endfunction

  function automatic logic [RUN_W-1:0] pow_c(int k);
    logic [RUN_W-1:0] p;
    p = RUN_W'(1);
    for (int n = 0; n < k; n++) begin
      p = p * RUN_W'(COUPLET_SPACE);
    end
    return p;
  endfunction

endpackage

// ===== hdl/mras_decode.sv =====
// First pipeline stage: depth saturation, partial checks and digit extraction.
// Depends on mras_pkg.
module mras_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  mras_pkg::req_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output mras_pkg::dec_t  dn_data
);

  logic           valid;
  mras_pkg::dec_t stage;
  mras_pkg::dec_t stage_next;

  function automatic mras_pkg::depth_t clamp(logic [mras_pkg::FDEPTH_W-1:0] d);
    return (d > mras_pkg::FDEPTH_W'(mras_pkg::MAX_DEPTH)) ?
           mras_pkg::CNT_W'(mras_pkg::MAX_DEPTH) : mras_pkg::CNT_W'(d);
  endfunction

  function automatic logic any_part(logic [mras_pkg::PART_W-1:0] p, mras_pkg::depth_t d);
    logic [mras_pkg::MAX_DEPTH-1:0] m;
    for (int i = 0; i < mras_pkg::MAX_DEPTH; i++) begin
      m[i] = (mras_pkg::CNT_W'(i) < d);
    end
    return |(p[mras_pkg::MAX_DEPTH-1:0] & m);
  endfunction

  always_comb begin
    logic [mras_pkg::ELEM_W-1:0] oe;
    logic [mras_pkg::ELEM_W-1:0] be;
    stage_next.op     = mras_pkg::op_t'(up_data.opcode);
    stage_next.on     = clamp(up_data.origin_depth);
    stage_next.bn     = clamp(up_data.bound_depth);
    stage_next.o_part = any_part(up_data.origin_partial, stage_next.on);
    stage_next.b_part = any_part(up_data.bound_partial, stage_next.bn);
    for (int i = 0; i < mras_pkg::MAX_DEPTH; i++) begin
      oe = up_data.origin_digits[mras_pkg::ADDR_W-1-mras_pkg::ELEM_W*i -: mras_pkg::ELEM_W];
      be = up_data.bound_digits[mras_pkg::ADDR_W-1-mras_pkg::ELEM_W*i -: mras_pkg::ELEM_W];
      stage_next.oraw[i] = oe;
      stage_next.od[i]   = mras_pkg::digit_of(oe);
      stage_next.bd[i]   = mras_pkg::digit_of(be);
    end
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== hdl/mras_arith.sv =====
// Second pipeline stage: increment with carry for the successor, subtract with
// borrow for the span, and the early status checks. Depends on mras_pkg.
module mras_arith (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  mras_pkg::dec_t   up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output mras_pkg::arith_t dn_data
);

  logic             valid;
  mras_pkg::arith_t stage;
  mras_pkg::arith_t stage_next;

  always_comb begin
    logic                          carry;
    logic                          borrow;
    logic [mras_pkg::DIFF_W-1:0]   a;
    logic [mras_pkg::DIFF_W-1:0]   b;
    mras_pkg::digit_vec_t          code;
    mras_pkg::digit_vec_t          diff;
    carry = 1'b1;
    borrow = 1'b0;
    a = '0;
    b = '0;
    code = '0;
    diff = '0;
    stage_next.inc  = '0;
    stage_next.zero = '0;
    for (int i = mras_pkg::MAX_DEPTH - 1; i >= 0; i--) begin
      if (mras_pkg::CNT_W'(i) >= up_data.on) begin
        stage_next.zero[i] = 1'b1;
      end else begin
        if (carry) begin
          if (up_data.od[i] == mras_pkg::DIGIT_MAX) begin
            stage_next.zero[i] = 1'b1;
          end else begin
            stage_next.inc[i] = 1'b1;
            code[i] = up_data.od[i] + mras_pkg::DIGIT_W'(1);
            carry = 1'b0;
          end
        end
        a = mras_pkg::DIFF_W'(up_data.bd[i]);
        b = mras_pkg::DIFF_W'(up_data.od[i]) + mras_pkg::DIFF_W'(borrow);
        if (a >= b) begin
          diff[i] = mras_pkg::DIGIT_W'(a - b);
          borrow = 1'b0;
        end else begin
          diff[i] = mras_pkg::DIGIT_W'(a + mras_pkg::DIFF_W'(mras_pkg::COUPLET_SPACE) - b);
          borrow = 1'b1;
        end
      end
    end

    stage_next.op    = up_data.op;
    stage_next.depth = up_data.on;
    stage_next.oraw  = up_data.oraw;
    stage_next.val   = (up_data.op == mras_pkg::OP_SUCC) ? code : diff;

    if (up_data.op == mras_pkg::OP_SUCC) begin
      if (up_data.on == '0) begin
        stage_next.status = mras_pkg::ST_EMPTY;
      end else if (up_data.o_part) begin
        stage_next.status = mras_pkg::ST_PARTIAL;
      end else if (carry) begin
        stage_next.status = mras_pkg::ST_CARRY;
      end else begin
        stage_next.status = mras_pkg::ST_OK;
      end
    end else begin
      if (up_data.on != up_data.bn) begin
        stage_next.status = mras_pkg::ST_DEPTH;
      end else if (up_data.o_part || up_data.b_part) begin
        stage_next.status = mras_pkg::ST_PARTIAL;
      end else if (borrow) begin
        stage_next.status = mras_pkg::ST_BACKWARD;
      end else begin
        stage_next.status = mras_pkg::ST_OK;
      end
    end
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== hdl/mras_convert.sv =====
// Third pipeline stage: repack the successor elements into symbols, and weight
// the right-aligned difference digits into two partial sums. Depends on mras_pkg.
module mras_convert (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  mras_pkg::arith_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output mras_pkg::conv_t  dn_data
);

  logic            valid;
  mras_pkg::conv_t stage;
  mras_pkg::conv_t stage_next;

  always_comb begin
    logic [mras_pkg::ELEM_W-1:0] e;
    mras_pkg::digit_vec_t        just;
    logic [mras_pkg::RUN_W-1:0]  term;
    stage_next.op     = up_data.op;
    stage_next.status = up_data.status;
    stage_next.next   = '0;
    stage_next.sum_a  = '0;
    stage_next.sum_b  = '0;
    just = '0;
    for (int i = 0; i < mras_pkg::MAX_DEPTH; i++) begin
      if (up_data.inc[i]) begin
        e = mras_pkg::split_code(up_data.val[i]);
      end else if (up_data.zero[i]) begin
        e = '0;
      end else begin
        e = up_data.oraw[i];
      end
      stage_next.next[mras_pkg::ADDR_W-1-mras_pkg::ELEM_W*i -: mras_pkg::ELEM_W] = e;
    end
    for (int j = 0; j < mras_pkg::MAX_DEPTH; j++) begin
      for (int k = 0; k < mras_pkg::MAX_DEPTH; k++) begin
        if (k + mras_pkg::MAX_DEPTH - int'(up_data.depth) == j) begin
          just[j] = up_data.val[k];
        end
      end
      term = mras_pkg::RUN_W'(just[j]) * mras_pkg::pow_c(mras_pkg::MAX_DEPTH - 1 - j);
      if (j % 2 == 0) begin
        stage_next.sum_a = stage_next.sum_a + term;
      end else begin
        stage_next.sum_b = stage_next.sum_b + term;
      end
    end
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== hdl/mras_finish.sv =====
// Last pipeline stage and output register: final add of the span count,
// overflow check and masking of the unused result field. Depends on mras_pkg.
module mras_finish (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  mras_pkg::conv_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output mras_pkg::rsp_t  dn_data
);

  logic           valid;
  mras_pkg::rsp_t stage;
  mras_pkg::rsp_t stage_next;

  always_comb begin
    logic [mras_pkg::RUN_W:0] total;
    mras_pkg::status_t        st;
    total = (mras_pkg::RUN_W+1)'(up_data.sum_a)
          + (mras_pkg::RUN_W+1)'(up_data.sum_b) + (mras_pkg::RUN_W+1)'(1);
    st = up_data.status;
    if (st == mras_pkg::ST_OK && up_data.op == mras_pkg::OP_SPAN && total[mras_pkg::RUN_W]) begin
      st = mras_pkg::ST_TOO_LARGE;
    end
    stage_next.status      = st;
    stage_next.next_digits = (st == mras_pkg::ST_OK && up_data.op == mras_pkg::OP_SUCC) ?
                             up_data.next : '0;
    stage_next.run_length  = (st == mras_pkg::ST_OK && up_data.op == mras_pkg::OP_SPAN) ?
                             total[mras_pkg::RUN_W-1:0] : '0;
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== hdl/mixed_radix_address_step.sv =====
// Top level of the mixed-radix address step block: four-stage pipeline with
// valid/stall channels. Depends on mras_pkg and the four mras stage modules.
//
// Successor and inclusive span arithmetic on addresses of up to MAX_DEPTH
// two-symbol digits. One transaction is taken every cycle while rsp_stall is
// low, and its result passes through the four register stages (digit
// decode, carry/borrow chain, repack and digit weighting, final add and output
// register). Each stage holds its contents while the stage below is full and
// stalled, so bubbles close up and nothing is lost or repeated. No state is kept
// between transactions and reset only clears the stage valid bits.
module mixed_radix_address_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mras_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mras_pkg::rsp_t rsp
);

  logic             dec_ready;
  logic             dec_valid;
  mras_pkg::dec_t   dec_data;
  logic             ar_ready;
  logic             ar_valid;
  mras_pkg::arith_t ar_data;
  logic             cv_ready;
  logic             cv_valid;
  mras_pkg::conv_t  cv_data;
  logic             fin_ready;

  assign req_stall = !dec_ready;

  mras_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_ready (dec_ready),
    .up_data  (req),
    .dn_valid (dec_valid),
    .dn_ready (ar_ready),
    .dn_data  (dec_data)
  );

  mras_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .up_ready (ar_ready),
    .up_data  (dec_data),
    .dn_valid (ar_valid),
    .dn_ready (cv_ready),
    .dn_data  (ar_data)
  );

  mras_convert u_convert (
    .clk      (clk),
    .rst      (rst),
    .up_valid (ar_valid),
    .up_ready (cv_ready),
    .up_data  (ar_data),
    .dn_valid (cv_valid),
    .dn_ready (fin_ready),
    .dn_data  (cv_data)
  );

  mras_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cv_valid),
    .up_ready (fin_ready),
    .up_data  (cv_data),
    .dn_valid (rsp_valid),
    .dn_ready (!rsp_stall),
    .dn_data  (rsp)
  );

endmodule
